### rtl/grp_pkg.sv
// shared constants, codes and control structs of the generation ring block
package grp_pkg;

	// sizing of the block
	localparam int NUM_INSTANCES  = 4;
	localparam int CALLBACK_SLOTS = 4;
	localparam int QUEUE_MAX      = 16;
	localparam int SAMPLE_BITS    = 64;

	// fixed field widths
	localparam int DATA_W = 64;
	localparam int GEN_W  = 32;
	localparam int CNT_W  = 16;
	localparam int CB_W   = 8;
	localparam int REQ_W  = 4;
	localparam int INST_W = 3;
	localparam int QLEN_W = 5;

	// derived index widths
	localparam int IW  = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;
	localparam int SW  = (CALLBACK_SLOTS > 1) ? $clog2(CALLBACK_SLOTS) : 1;
	localparam int QW  = (QUEUE_MAX > 1) ? $clog2(QUEUE_MAX) : 1;
	localparam int QLW = $clog2(QUEUE_MAX + 1) + 1;
	localparam int AW  = IW + QW;
	localparam int MEM_DEPTH = NUM_INSTANCES * (1 << QW);

	localparam logic [GEN_W-1:0] GEN_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// remainder unit: quotient bits retired per cycle
	localparam int MOD_DIGITS = 4;
	localparam int MOD_STEPS  = GEN_W / MOD_DIGITS;
	localparam int MSW        = $clog2(MOD_STEPS);

	typedef enum logic [REQ_W-1:0] {
		REQ_PUBLISH     = 4'd0,
		REQ_COPY        = 4'd1,
		REQ_COPY_LATEST = 4'd2,
		REQ_UPDATED     = 4'd3,
		REQ_ADVERTISE   = 4'd4,
		REQ_UNADVERTISE = 4'd5,
		REQ_CLAIM       = 4'd6,
		REQ_REG_CB      = 4'd7,
		REQ_UNREG_CB    = 4'd8
	} req_t;

	typedef enum logic [1:0] {
		EM_STATUS,
		EM_WAKE,
		EM_PUB_DONE,
		EM_COPY_DONE
	} emit_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WINDOW,
		ST_MOD_START,
		ST_MOD_WAIT,
		ST_WRITE,
		ST_WAKE,
		ST_READ,
		ST_COPY_DONE,
		ST_PUB_DONE,
		ST_STATUS
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  load;
		logic  decode;
		logic  window;
		logic  mod_start;
		logic  mem_write;
		logic  mem_read;
		logic  wake_next;
		logic  emit;
		emit_t kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pub_go;
		logic copy_go;
		logic is_pub;
		logic mod_busy;
		logic wake_hit;
		logic wake_end;
		logic out_free;
	} sts_t;

endpackage

### rtl/grp_mod.sv
// iterative remainder unit: 32-bit value modulo the effective queue length
module grp_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [grp_pkg::GEN_W-1:0] dividend,
	input  logic [grp_pkg::QLW-1:0]   divisor,
	output logic                      busy,
	output logic [grp_pkg::QW-1:0]    rem
);
	import grp_pkg::*;

	logic             busy_q;
	logic [MSW-1:0]   step_q;
	logic [GEN_W-1:0] dvd_q;
	logic [QLW-1:0]   rem_q;
	logic [QLW-1:0]   div_q;
	logic [QLW-1:0]   rem_next;

	// retire several dividend bits per cycle, restoring compare and subtract
	always_comb begin
		logic [QLW:0]   t;
		logic [QLW-1:0] r;
		r = rem_q;
		for (int k = 0; k < MOD_DIGITS; k++) begin
			t = {r, dvd_q[GEN_W-1-k]};
			if (t >= {1'b0, div_q})
				t = t - {1'b0, div_q};
			r = t[QLW-1:0];
		end
		rem_next = r;
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + MSW'(1);
			if (step_q == MSW'(MOD_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	// operand and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_q << MOD_DIGITS;
			rem_q <= rem_next;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q[QW-1:0];

endmodule

### rtl/grp_dp.sv
// datapath: per-instance state, sample memory, window math and result register
module grp_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [grp_pkg::QLEN_W-1:0]      cfg_data,
	input  logic [grp_pkg::REQ_W-1:0]       req_type,
	input  logic [grp_pkg::INST_W-1:0]      instance_req,
	input  logic [grp_pkg::DATA_W-1:0]      sample_data,
	input  logic [grp_pkg::GEN_W-1:0]       reader_generation,
	input  logic [grp_pkg::CB_W-1:0]        callback_id,
	input  grp_pkg::cmd_t                   cmd,
	output grp_pkg::sts_t                   sts,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            ok,
	output logic [grp_pkg::DATA_W-1:0]      read_data,
	output logic [grp_pkg::GEN_W-1:0]       new_generation,
	output logic [grp_pkg::INST_W-1:0]      claimed_instance,
	output logic [grp_pkg::CB_W-1:0]        wake_id,
	output logic                            last
);
	import grp_pkg::*;

	logic [QLEN_W-1:0]      qlen_q;
	logic [QLW-1:0]         q_eff;

	logic [REQ_W-1:0]       req_q;
	logic [INST_W-1:0]      inst_q;
	logic [SAMPLE_BITS-1:0] data_q;
	logic [GEN_W-1:0]       rgen_q;
	logic [CB_W-1:0]        cb_q;

	logic [GEN_W-1:0]       gen_q [NUM_INSTANCES];
	logic [CNT_W-1:0]       cnt_q [NUM_INSTANCES];
	logic [CB_W-1:0]        tab_q [NUM_INSTANCES][CALLBACK_SLOTS];

	logic [SAMPLE_BITS-1:0] mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]   vld_q;
	logic [SAMPLE_BITS-1:0] rd_q;
	logic                   rdv_q;

	logic [GEN_W-1:0]       oldest_m1_q;
	logic [GEN_W-1:0]       operand_q;
	logic [SW-1:0]          wslot_q;

	logic                   inst_ok;
	logic [IW-1:0]          iw;
	logic [GEN_W-1:0]       newest;
	logic [CNT_W-1:0]       cnt;
	logic [CB_W-1:0]        row [CALLBACK_SLOTS];
	logic                   win_reset;
	logic [QW-1:0]          rem;
	logic                   mod_busy;
	logic [AW-1:0]          addr;

	logic                   st_ok;
	logic [GEN_W-1:0]       st_gen;
	logic [INST_W-1:0]      st_claim;
	logic                   st_apply;
	logic                   cnt_we;
	logic [IW-1:0]          cnt_idx;
	logic [CNT_W-1:0]       cnt_val;
	logic [CALLBACK_SLOTS-1:0] tab_we;
	logic [CB_W-1:0]        tab_val [CALLBACK_SLOTS];

	logic                   out_valid_q;
	logic                   ok_q;
	logic [DATA_W-1:0]      read_data_q;
	logic [GEN_W-1:0]       new_gen_q;
	logic [INST_W-1:0]      claim_q;
	logic [CB_W-1:0]        wake_q;
	logic                   last_q;

	// queue length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			qlen_q <= QLEN_W'(1);
		else if (cfg_valid)
			qlen_q <= cfg_data;
	end

	// zero acts as one, oversize clamps to the ring depth
	always_comb begin
		if (qlen_q == '0)
			q_eff = QLW'(1);
		else if (int'(qlen_q) > QUEUE_MAX)
			q_eff = QLW'(QUEUE_MAX);
		else
			q_eff = QLW'(qlen_q);
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			inst_q <= instance_req;
			data_q <= sample_data[SAMPLE_BITS-1:0];
			rgen_q <= reader_generation;
			cb_q   <= callback_id;
		end
	end

	// per-instance view
	always_comb begin
		inst_ok = ({1'b0, inst_q} < (INST_W + 1)'(NUM_INSTANCES));
		iw      = inst_q[IW-1:0];
		newest  = gen_q[iw];
		cnt     = cnt_q[iw];
		row     = tab_q[iw];
	end

	assign win_reset = (rgen_q == '0) || (rgen_q > newest) || (rgen_q < oldest_m1_q);

	// window bounds, then the generation just before the one to hand out
	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			oldest_m1_q <= (newest > GEN_W'(q_eff)) ? newest - GEN_W'(q_eff) : '0;
			operand_q   <= newest;
		end else if (cmd.window) begin
			if (req_q == REQ_COPY_LATEST)
				operand_q <= newest - GEN_W'(1);
			else if (win_reset)
				operand_q <= oldest_m1_q;
			else
				operand_q <= rgen_q;
		end
	end

	grp_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (operand_q),
		.divisor  (q_eff),
		.busy     (mod_busy),
		.rem      (rem)
	);

	assign addr = {iw, rem};

	// sample memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_write)
			mem_q[addr] <= data_q;
		if (cmd.mem_read) begin
			rd_q  <= mem_q[addr];
			rdv_q <= vld_q[addr];
		end
	end

	// written marks, an unwritten slot reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (cmd.mem_write)
			vld_q[addr] <= 1'b1;
	end

	// status result and the state update it carries
	always_comb begin
		logic found;
		st_ok    = 1'b0;
		st_gen   = '0;
		st_claim = '0;
		cnt_we   = 1'b0;
		cnt_idx  = iw;
		cnt_val  = cnt;
		tab_we   = '0;
		found    = 1'b0;
		for (int i = 0; i < CALLBACK_SLOTS; i++)
			tab_val[i] = row[i];
		if (req_q == REQ_CLAIM) begin
			for (int i = 0; i < NUM_INSTANCES; i++) begin
				if (!st_ok && cnt_q[i] == '0) begin
					st_ok    = 1'b1;
					st_claim = INST_W'(i);
					cnt_we   = 1'b1;
					cnt_idx  = IW'(i);
					cnt_val  = CNT_W'(1);
				end
			end
		end else if (req_q > REQ_UNREG_CB) begin
			st_ok = 1'b0;
		end else if (!inst_ok) begin
			if (req_q inside {REQ_COPY, REQ_COPY_LATEST})
				st_gen = rgen_q;
		end else begin
			case (req_q)
				REQ_COPY, REQ_COPY_LATEST: begin
					st_gen = (newest != '0) ? rgen_q : '0;
				end
				REQ_UPDATED: begin
					st_ok = (newest != rgen_q);
				end
				REQ_ADVERTISE: begin
					if (cnt != CNT_MAX) begin
						st_ok   = 1'b1;
						cnt_we  = 1'b1;
						cnt_val = cnt + CNT_W'(1);
					end
				end
				REQ_UNADVERTISE: begin
					st_ok = 1'b1;
					if (cnt != '0) begin
						cnt_we  = 1'b1;
						cnt_val = cnt - CNT_W'(1);
					end
				end
				REQ_REG_CB: begin
					if (cb_q != '0) begin
						for (int i = 0; i < CALLBACK_SLOTS; i++)
							if (row[i] == cb_q)
								found = 1'b1;
						st_ok = found;
						for (int i = 0; i < CALLBACK_SLOTS; i++) begin
							if (!st_ok && row[i] == '0) begin
								st_ok      = 1'b1;
								tab_we[i]  = 1'b1;
								tab_val[i] = cb_q;
							end
						end
					end
				end
				REQ_UNREG_CB: begin
					if (cb_q != '0) begin
						st_ok = 1'b1;
						for (int i = 0; i < CALLBACK_SLOTS; i++) begin
							if (row[i] == cb_q) begin
								tab_we[i]  = 1'b1;
								tab_val[i] = '0;
							end
						end
					end
				end
				default: begin
					st_ok = 1'b0;
				end
			endcase
		end
	end

	assign st_apply = cmd.emit && (cmd.kind == EM_STATUS);

	// generation counts, publisher counts, callback table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_INSTANCES; i++) begin
				gen_q[i] <= '0;
				cnt_q[i] <= '0;
				for (int j = 0; j < CALLBACK_SLOTS; j++)
					tab_q[i][j] <= '0;
			end
		end else begin
			if (cmd.mem_write)
				gen_q[iw] <= newest + GEN_W'(1);
			if (st_apply && cnt_we)
				cnt_q[cnt_idx] <= cnt_val;
			if (st_apply) begin
				for (int j = 0; j < CALLBACK_SLOTS; j++)
					if (tab_we[j])
						tab_q[iw][j] <= tab_val[j];
			end
		end
	end

	// wake scan slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wslot_q <= '0;
		else if (cmd.load)
			wslot_q <= '0;
		else if (cmd.wake_next)
			wslot_q <= wslot_q + SW'(1);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.kind)
				EM_WAKE: begin
					ok_q        <= 1'b1;
					read_data_q <= '0;
					new_gen_q   <= '0;
					claim_q     <= '0;
					wake_q      <= row[wslot_q];
					last_q      <= 1'b0;
				end
				EM_PUB_DONE: begin
					ok_q        <= 1'b1;
					read_data_q <= '0;
					new_gen_q   <= '0;
					claim_q     <= '0;
					wake_q      <= '0;
					last_q      <= 1'b1;
				end
				EM_COPY_DONE: begin
					ok_q        <= 1'b1;
					read_data_q <= rdv_q ? DATA_W'(rd_q) : '0;
					new_gen_q   <= operand_q + GEN_W'(1);
					claim_q     <= '0;
					wake_q      <= '0;
					last_q      <= 1'b1;
				end
				default: begin
					ok_q        <= st_ok;
					read_data_q <= '0;
					new_gen_q   <= st_gen;
					claim_q     <= st_claim;
					wake_q      <= '0;
					last_q      <= 1'b1;
				end
			endcase
		end
	end

	// status toward the controller
	always_comb begin
		sts.pub_go   = (req_q == REQ_PUBLISH) && inst_ok && (cnt != '0) && (newest != GEN_MAX);
		sts.copy_go  = (req_q inside {REQ_COPY, REQ_COPY_LATEST}) && inst_ok &&
			(newest != '0) && (newest != rgen_q);
		sts.is_pub   = (req_q == REQ_PUBLISH);
		sts.mod_busy = mod_busy;
		sts.wake_hit = (row[wslot_q] != '0);
		sts.wake_end = (wslot_q == SW'(CALLBACK_SLOTS - 1));
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid        = out_valid_q;
	assign ok               = ok_q;
	assign read_data        = read_data_q;
	assign new_generation   = new_gen_q;
	assign claimed_instance = claim_q;
	assign wake_id          = wake_q;
	assign last             = last_q;

endmodule

### rtl/grp_ctrl.sv
// controller: sequences decode, window, remainder, memory access and results
module grp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output grp_pkg::cmd_t cmd,
	input  grp_pkg::sts_t sts
);
	import grp_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   wake_adv;

	// a slot with no id is skipped, a slot with an id waits for room
	assign wake_adv = !sts.wake_hit || sts.out_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (sts.pub_go)
					state_d = ST_MOD_START;
				else if (sts.copy_go)
					state_d = ST_WINDOW;
				else
					state_d = ST_STATUS;
			end
			ST_WINDOW:    state_d = ST_MOD_START;
			ST_MOD_START: state_d = ST_MOD_WAIT;
			ST_MOD_WAIT: begin
				if (!sts.mod_busy)
					state_d = sts.is_pub ? ST_WRITE : ST_READ;
			end
			ST_WRITE:     state_d = ST_WAKE;
			ST_WAKE: begin
				if (wake_adv && sts.wake_end)
					state_d = ST_PUB_DONE;
			end
			ST_READ:      state_d = ST_COPY_DONE;
			ST_COPY_DONE, ST_PUB_DONE, ST_STATUS: begin
				if (sts.out_free)
					state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		cmd.kind = EM_STATUS;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DECODE:    cmd.decode    = 1'b1;
			ST_WINDOW:    cmd.window    = 1'b1;
			ST_MOD_START: cmd.mod_start = 1'b1;
			ST_WRITE:     cmd.mem_write = 1'b1;
			ST_READ:      cmd.mem_read  = 1'b1;
			ST_WAKE: begin
				cmd.wake_next = wake_adv;
				cmd.emit      = sts.wake_hit && sts.out_free;
				cmd.kind      = EM_WAKE;
			end
			ST_COPY_DONE: begin
				cmd.emit = sts.out_free;
				cmd.kind = EM_COPY_DONE;
			end
			ST_PUB_DONE: begin
				cmd.emit = sts.out_free;
				cmd.kind = EM_PUB_DONE;
			end
			ST_STATUS: begin
				cmd.emit = sts.out_free;
				cmd.kind = EM_STATUS;
			end
			default: begin
				cmd.kind = EM_STATUS;
			end
		endcase
	end

endmodule

### rtl/generation_ring_pubsub.sv
// Generation-stamped overwriting sample ring with publishers and wake callbacks.
// Requests enter on the in channel (valid/ready), one beat per request; each
// request returns one or more beats on the out channel, the final one marked by
// last. A successful publish first returns one wake beat per registered callback
// id of the instance, in slot order. The cfg channel writes queue_length and is
// always ready; it is to be written only while no request is in flight, which
// the user must ensure, as the block itself does not enforce it. Status-only
// requests go from decode straight to the result; copy and copy_latest pass
// through the window step, the remainder unit and a registered memory read;
// publish through the remainder unit, the memory write and a scan of the four
// callback slots. A new request is taken once the final result has entered the
// output register. The slot remainder unit retires four generation bits per cycle.
// Reset clears all generation counts, publisher counts, the callback table and
// the sample ring (through per-slot written marks), and sets queue_length to 1.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits in place; input stays blocked until the request completes.
module generation_ring_pubsub (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [grp_pkg::QLEN_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [grp_pkg::REQ_W-1:0]       req_type,
	input  logic [grp_pkg::INST_W-1:0]      instance_req,
	input  logic [grp_pkg::DATA_W-1:0]      sample_data,
	input  logic [grp_pkg::GEN_W-1:0]       reader_generation,
	input  logic [grp_pkg::CB_W-1:0]        callback_id,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            ok,
	output logic [grp_pkg::DATA_W-1:0]      read_data,
	output logic [grp_pkg::GEN_W-1:0]       new_generation,
	output logic [grp_pkg::INST_W-1:0]      claimed_instance,
	output logic [grp_pkg::CB_W-1:0]        wake_id,
	output logic                            last
);
	import grp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// configuration register is written the cycle it arrives
	assign cfg_ready = 1'b1;

	grp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	grp_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_data          (cfg_data),
		.req_type          (req_type),
		.instance_req      (instance_req),
		.sample_data       (sample_data),
		.reader_generation (reader_generation),
		.callback_id       (callback_id),
		.cmd               (cmd),
		.sts               (sts),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.ok                (ok),
		.read_data         (read_data),
		.new_generation    (new_generation),
		.claimed_instance  (claimed_instance),
		.wake_id           (wake_id),
		.last              (last)
	);

endmodule

### rtl/grp_chk.sv
// port-level checks of the generation ring block, bound to the top level
module grp_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [grp_pkg::QLEN_W-1:0]      cfg_data,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [grp_pkg::REQ_W-1:0]       req_type,
	input logic [grp_pkg::INST_W-1:0]      instance_req,
	input logic [grp_pkg::DATA_W-1:0]      sample_data,
	input logic [grp_pkg::GEN_W-1:0]       reader_generation,
	input logic [grp_pkg::CB_W-1:0]        callback_id,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            ok,
	input logic [grp_pkg::DATA_W-1:0]      read_data,
	input logic [grp_pkg::GEN_W-1:0]       new_generation,
	input logic [grp_pkg::INST_W-1:0]      claimed_instance,
	input logic [grp_pkg::CB_W-1:0]        wake_id,
	input logic                            last
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(last) &&
		$stable(wake_id) && $stable(read_data) && $stable(new_generation))
		else $error("result beat changed while stalled");

	// one request at a time: no second beat right after an accepted one
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accepting a request");

	// non-final beats are wake beats only
	a_wake_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> ok && (wake_id != '0) && (read_data == '0))
		else $error("non-final beat is not a wake beat");

	// a claimed instance only appears on a successful final beat
	a_claim_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (claimed_instance != '0) |-> ok && last && (wake_id == '0))
		else $error("claimed instance on a wrong beat");

endmodule

bind generation_ring_pubsub grp_chk u_grp_chk (.*);
